### design/dta_pkg.sv
// shared types, widths and register codes for the displacement texel addresser
// used by the channel interfaces, the address unit and the top level
`timescale 1ns / 1ps
`default_nettype none

package dta_pkg;

  localparam int unsigned PosW      = 10;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IndexW    = 20;
  localparam int unsigned WidthW    = 10;
  localparam int unsigned RowLowW   = 10;
  localparam int unsigned RowHighW  = 11;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned CoordW    = 12;

  localparam logic [WidthW-1:0]   TexWidthRst = 10'd320;
  localparam logic [RowLowW-1:0]  RowLowRst   = 10'd0;
  localparam logic [RowHighW-1:0] RowHighRst  = 11'd240;

  typedef enum logic [CfgIdxW-1:0] {
    RegTexWidth   = 3'd0,
    RegRowLow     = 3'd1,
    RegRowHigh    = 3'd2,
    RegMirrorMode = 3'd3,
    RegOffsetMode = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [WidthW-1:0]   tex_width;
    logic [RowLowW-1:0]  row_low;
    logic [RowHighW-1:0] row_high;
    logic                mirror_mode;
    logic                offset_mode;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [ByteW-1:0] vert_a;
    logic [ByteW-1:0] vert_b;
    logic [ByteW-1:0] horiz_a;
    logic [ByteW-1:0] horiz_b;
  } pix_t;

  typedef logic signed [CoordW-1:0] coord_t;

endpackage

`default_nettype wire

### design/dta_if.sv
// valid/ready channel interfaces: pixel input, texel index output, register writes
// depends on dta_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dta_in_if;
  import dta_pkg::*;
  logic             valid;
  logic             ready;
  logic [PosW-1:0]  pos_x;
  logic [PosW-1:0]  pos_y;
  logic [ByteW-1:0] vert_a;
  logic [ByteW-1:0] vert_b;
  logic [ByteW-1:0] horiz_a;
  logic [ByteW-1:0] horiz_b;
  modport source (output valid, pos_x, pos_y, vert_a, vert_b, horiz_a, horiz_b,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, vert_a, vert_b, horiz_a, horiz_b,
                  output ready);
endinterface

interface dta_out_if;
  import dta_pkg::*;
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] texel_index;
  modport source (output valid, texel_index, input ready);
  modport sink   (input valid, texel_index, output ready);
endinterface

interface dta_cfg_if;
  import dta_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

### design/displacement_texel_addresser.sv
// top level of the displacement texel addresser: register file and item pipeline
// depends on dta_pkg, dta_if and dta_addr
//
// usage:
//   in_i   carries one pixel item: coordinates and four height mask bytes
//   out_o  carries one texel index item for each pixel item, in order
//   cfg_i  writes the registers by index: 0 tex_width, 1 row_low, 2 row_high,
//          3 mirror_mode, 4 offset_mode; other indexes are ignored
//   cfg_i is always ready; write registers only while no item is in flight
// timing:
//   three register stages (input capture, row/column, index); an accepted item
//   passes through input capture, then row/column, then index, and out_o.valid
//   rises when it reaches the index stage; one item per cycle sustained while
//   out_o.ready is high; the row times width multiply has a stage of its own
// reset:
//   rst_ni low empties the pipeline and loads tex_width 320, row_low 0,
//   row_high 240, clamp addressing and gradient mode
// stall:
//   when out_o.ready is low the stages fill and in_i.ready drops after
//   up to three more items have been taken; nothing is dropped
`timescale 1ns / 1ps
`default_nettype none

module displacement_texel_addresser (
  input  wire        clk_i,
  input  wire        rst_ni,
  dta_in_if.sink     in_i,
  dta_out_if.source  out_o,
  dta_cfg_if.sink    cfg_i
);
  import dta_pkg::*;

  cfg_t cfg_q;

  logic s0_valid_q, s1_valid_q, s2_valid_q;
  logic s0_ready, s1_ready, s2_ready;
  pix_t pix_q;
  coord_t row_d, col_d, row_q, col_q;
  logic signed [2*CoordW-2:0] prod;
  logic signed [2*CoordW-1:0] sum;
  logic [IndexW-1:0] index_q;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tex_width   <= TexWidthRst;
      cfg_q.row_low     <= RowLowRst;
      cfg_q.row_high    <= RowHighRst;
      cfg_q.mirror_mode <= 1'b0;
      cfg_q.offset_mode <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        RegTexWidth:   cfg_q.tex_width   <= cfg_i.wdata[WidthW-1:0];
        RegRowLow:     cfg_q.row_low     <= cfg_i.wdata[RowLowW-1:0];
        RegRowHigh:    cfg_q.row_high    <= cfg_i.wdata[RowHighW-1:0];
        RegMirrorMode: cfg_q.mirror_mode <= cfg_i.wdata[0];
        RegOffsetMode: cfg_q.offset_mode <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  assign s2_ready   = !s2_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_i.ready = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s0_ready) s0_valid_q <= in_i.valid;
      if (s1_ready) s1_valid_q <= s0_valid_q;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (s0_ready && in_i.valid) begin
      pix_q.pos_x   <= in_i.pos_x;
      pix_q.pos_y   <= in_i.pos_y;
      pix_q.vert_a  <= in_i.vert_a;
      pix_q.vert_b  <= in_i.vert_b;
      pix_q.horiz_a <= in_i.horiz_a;
      pix_q.horiz_b <= in_i.horiz_b;
    end
  end

  dta_addr u_addr (
    .cfg_i (cfg_q),
    .pix_i (pix_q),
    .row_o (row_d),
    .col_o (col_d)
  );

  always_ff @(posedge clk_i) begin
    if (s1_ready && s0_valid_q) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // row times stride plus column, wrapped to the index width
  always_comb begin
    prod = row_q * $signed({1'b0, cfg_q.tex_width});
    sum  = $signed({prod[2*CoordW-2], prod})
         + $signed({{CoordW{col_q[CoordW-1]}}, col_q});
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      index_q <= sum[IndexW-1:0];
    end
  end

  assign out_o.valid       = s2_valid_q;
  assign out_o.texel_index = index_q;

endmodule

`default_nettype wire

### design/dta_addr.sv
// displacement and edge addressing: turns one pixel item into texture row and column
// depends on dta_pkg
`timescale 1ns / 1ps
`default_nettype none

module dta_addr (
  input  dta_pkg::cfg_t   cfg_i,
  input  dta_pkg::pix_t   pix_i,
  output dta_pkg::coord_t row_o,
  output dta_pkg::coord_t col_o
);
  import dta_pkg::*;

  localparam int unsigned WideW = CoordW + 1;

  logic [ByteW-1:0]        dx_diff, dy_diff;
  logic signed [WideW-1:0] dx, dy;
  logic signed [WideW-1:0] c, r, w, lo, hi, col_w, row_w, mir_r;

  always_comb begin
    dx_diff = pix_i.horiz_a - pix_i.horiz_b;
    dy_diff = pix_i.vert_a - pix_i.vert_b;
    if (cfg_i.offset_mode) begin
      dx = $signed({(WideW-ByteW)'(0), pix_i.horiz_a});
      dy = $signed({(WideW-ByteW)'(0), pix_i.vert_a});
    end else begin
      dx = $signed({{(WideW-ByteW){dx_diff[ByteW-1]}}, dx_diff});
      dy = $signed({{(WideW-ByteW){dy_diff[ByteW-1]}}, dy_diff});
    end

    c  = $signed({(WideW-PosW)'(0), pix_i.pos_x}) + dx;
    r  = $signed({(WideW-PosW)'(0), pix_i.pos_y}) + dy;
    w  = $signed({(WideW-WidthW)'(0), cfg_i.tex_width});
    lo = $signed({(WideW-RowLowW)'(0), cfg_i.row_low});
    hi = $signed({(WideW-RowHighW)'(0), cfg_i.row_high});

    // column: clamp or mirror at both edges
    if (c < 0) begin
      col_w = cfg_i.mirror_mode ? -c : '0;
    end else if (c < w) begin
      col_w = c;
    end else begin
      col_w = cfg_i.mirror_mode ? (w + w - c - 1) : (w - 1);
    end

    // row: clamp below, clamp or mirror above, mirrored row floored at zero
    mir_r = hi + hi - r - 1;
    if (r < lo) begin
      row_w = lo;
    end else if (r < hi) begin
      row_w = r;
    end else if (!cfg_i.mirror_mode) begin
      row_w = hi - 1;
    end else begin
      row_w = (mir_r < 0) ? '0 : mir_r;
    end
  end

  assign col_o = col_w[CoordW-1:0];
  assign row_o = row_w[CoordW-1:0];

endmodule

`default_nettype wire
